FILE: rtl/srr_pkg.sv
// ----------------------------------------------------------------------------
// srr_pkg: shared types and codes of the selective-repeat receiver
// Holds the transaction structs shared by the front and back parts, the flag
// codes used by the front, and the kind and phase codes and sequencer state type used by the back.
// ----------------------------------------------------------------------------
package srr_pkg;

  typedef struct packed {
    logic        func;
    logic [31:0] seq;
    logic [2:0]  flag;
    logic [31:0] payload;
  } srr_in_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic        resp_is_srej;
    logic [31:0] number;
    logic [31:0] out_seq;
    logic [31:0] data_word;
    logic        last;
  } srr_out_t;

  // classification made by the front part
  typedef struct packed {
    logic is_timeout;
    logic is_data;
    logic is_filename;
    logic is_window;
    logic is_eof;
  } srr_cls_t;

  typedef struct packed {
    srr_in_t  item;
    srr_cls_t cls;
  } srr_qent_t;

  localparam logic [2:0] FL_DATA     = 3'd0;
  localparam logic [2:0] FL_FILENAME = 3'd1;
  localparam logic [2:0] FL_WINDOW   = 3'd2;
  localparam logic [2:0] FL_EOF      = 3'd3;
  localparam logic [2:0] FL_QUIT     = 3'd4;
  localparam logic [2:0] FL_OTHER    = 3'd5;

  localparam logic [1:0] KIND_DELIVER = 2'd0;
  localparam logic [1:0] KIND_RESP    = 2'd1;
  localparam logic [1:0] KIND_DONE    = 2'd2;

  // slot word: eof bit, sequence number, payload
  localparam int SLOT_W = 65;

  typedef enum logic [2:0] {
    PH_FILENAME,
    PH_WINDOW,
    PH_DATA,
    PH_EOFCONF,
    PH_DONE
  } srr_phase_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RESP,
    ST_MOD,
    ST_BUF,
    ST_DR_RD,
    ST_DR_CHK,
    ST_DR_END,
    ST_SL_RD,
    ST_SL_WR
  } srr_state_t;

endpackage

FILE: rtl/selective_repeat_receiver_top.sv
// ----------------------------------------------------------------------------
// selective_repeat_receiver_top: selective-repeat ARQ receiver
// Top level tying the intake queue to the session sequencer.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: drive in_item and raise start; the transaction is taken at
//   a rising edge with start high and busy low. busy rises while the
//   two-entry intake queue is full.
//   Result channel: each result sits on out_item for one cycle with
//   out_strobe high; the receiver cannot stall it. out_item.last marks the
//   final result of one input transaction.
//   Sequencing: an out-of-order packet first has its slot position worked out
//   by a one-bit-per-cycle remainder unit over the 32-bit sequence offset. A
//   drain reads each buffered slot through the slot memory's read port, and a
//   window slide reads and writes each slot moved and clears the rest.
//   Reset: synchronous, active low; returns to waiting for the filename with
//   an empty slot buffer (valid bits cleared at once, no clearing pass).
// ----------------------------------------------------------------------------
module selective_repeat_receiver_top
  import srr_pkg::*;
#(
  parameter int WINDOW_MAX = 16
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  input  srr_in_t  in_item,
  output logic     out_strobe,
  output srr_out_t out_item
);

  logic      q_valid;
  logic      q_pop;
  srr_qent_t q_head;

  // front: accept and classify, hold in queue
  srr_front u_front (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_item(in_item),
    .q_valid(q_valid), .q_head(q_head), .q_pop(q_pop)
  );

  // back: run phases, buffer, drain and slide
  srr_back #(.WINDOW_MAX(WINDOW_MAX)) u_back (
    .clk(clk), .rst_n(rst_n), .q_valid(q_valid), .q_head(q_head), .q_pop(q_pop),
    .out_strobe(out_strobe), .out_item(out_item)
  );

endmodule

FILE: rtl/srr_ram.sv
// ----------------------------------------------------------------------------
// srr_ram: generic single-write, single-read memory
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module srr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/srr_front.sv
// ----------------------------------------------------------------------------
// srr_front: intake and classification
// Accepts packet/timeout transactions, classifies them and holds them in a
// two-entry queue for the back part.
// ----------------------------------------------------------------------------
module srr_front
  import srr_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  srr_in_t   in_item,
  output logic      q_valid,
  output srr_qent_t q_head,
  input  logic      q_pop
);

  srr_qent_t  ent_r [2];
  logic       wr_r, wr_nxt;
  logic       rd_r, rd_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       push;
  srr_qent_t  new_ent;

  assign busy    = (cnt_r == 2'd2);
  assign push    = start && !busy;
  assign q_valid = (cnt_r != 2'd0);
  assign q_head  = ent_r[rd_r];

  always_comb begin
    new_ent.item            = in_item;
    new_ent.cls.is_timeout  = in_item.func;
    new_ent.cls.is_data     = (in_item.flag == FL_DATA);
    new_ent.cls.is_filename = (in_item.flag == FL_FILENAME);
    new_ent.cls.is_window   = (in_item.flag == FL_WINDOW);
    new_ent.cls.is_eof      = (in_item.flag == FL_EOF);
    wr_nxt  = push ? ~wr_r : wr_r;
    rd_nxt  = (q_pop && q_valid) ? ~rd_r : rd_r;
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, q_pop && q_valid};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= 1'b0;
      rd_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
    if (push) begin
      ent_r[wr_r] <= new_ent;
    end
  end

endmodule

FILE: rtl/srr_back.sv
// ----------------------------------------------------------------------------
// srr_back: session sequencer
// Runs the session phases, the slot-position modulo, buffer drain and
// window slide, and emits at most one result per cycle, none while it steps the modulo.
// ----------------------------------------------------------------------------
module srr_back
  import srr_pkg::*;
#(
  parameter int WINDOW_MAX = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      q_valid,
  input  srr_qent_t q_head,
  output logic      q_pop,
  output logic      out_strobe,
  output srr_out_t  out_item
);

  localparam int IW = $clog2(WINDOW_MAX);
  localparam int CW = $clog2(WINDOW_MAX + 1);
  localparam logic [CW-1:0] WMAX_C = CW'(WINDOW_MAX);

  srr_state_t st_r, st_nxt;
  srr_phase_t ph_r, ph_nxt;
  logic [CW-1:0] ws_r, ws_nxt;
  logic [31:0] exp_r, exp_nxt, hs_r, hs_nxt, cnt_r, cnt_nxt;
  logic quiet_r, quiet_nxt, bact_r, bact_nxt;
  logic [WINDOW_MAX-1:0] valid_r, valid_nxt;
  srr_qent_t item_r, item_nxt;
  logic [CW-1:0] idx_r, idx_nxt, n_r, n_nxt, rem_r, rem_nxt;
  logic [31:0] d_r, d_nxt;
  logic [4:0] bit_r, bit_nxt;
  logic strobe_nxt;
  srr_out_t out_nxt;
  logic [31:0] pend_r, pend_nxt;

  logic we;
  logic [IW-1:0] waddr, raddr;
  logic [SLOT_W-1:0] wdata, rdata;
  logic [CW:0] src;
  logic [CW:0] rem_sh;
  logic [31:0] exp_i;
  logic r_eof;
  logic [31:0] r_seq, r_pay;

  srr_ram #(.WIDTH(SLOT_W), .DEPTH(WINDOW_MAX)) u_slots (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
    .raddr(raddr), .rdata(rdata)
  );

  assign {r_eof, r_seq, r_pay} = rdata;
  assign src    = {1'b0, idx_r} + {1'b0, n_r};
  assign rem_sh = {rem_r, d_r[31]};
  assign exp_i  = exp_r + 32'(idx_r);

  always_comb begin
    st_nxt = st_r; ph_nxt = ph_r; ws_nxt = ws_r; exp_nxt = exp_r; hs_nxt = hs_r;
    cnt_nxt = cnt_r; quiet_nxt = quiet_r; bact_nxt = bact_r; valid_nxt = valid_r;
    item_nxt = item_r; idx_nxt = idx_r; n_nxt = n_r; rem_nxt = rem_r; d_nxt = d_r;
    bit_nxt = bit_r; pend_nxt = pend_r;
    strobe_nxt = 1'b0; out_nxt = '0;
    q_pop = 1'b0; we = 1'b0; waddr = '0; wdata = '0; raddr = '0;

    case (st_r)
      ST_IDLE: begin
        if (q_valid) begin
          q_pop = 1'b1;
          item_nxt = q_head;
          case (ph_r)
            PH_FILENAME: begin
              if (!q_head.cls.is_timeout) begin
                strobe_nxt = 1'b1; out_nxt.last = 1'b1;
                if (q_head.cls.is_filename) begin
                  out_nxt.kind = KIND_RESP; out_nxt.number = q_head.item.seq + 32'd1;
                  out_nxt.out_seq = cnt_r; cnt_nxt = cnt_r + 32'd1;
                  ph_nxt = PH_WINDOW;
                end else begin
                  out_nxt.kind = KIND_DONE; ph_nxt = PH_DONE;
                end
              end
            end
            PH_WINDOW: begin
              if (!q_head.cls.is_timeout && q_head.cls.is_window) begin
                if (q_head.item.payload == 32'd0) ws_nxt = CW'(1);
                else if (q_head.item.payload > 32'(WINDOW_MAX)) ws_nxt = WMAX_C;
                else ws_nxt = q_head.item.payload[CW-1:0];
                strobe_nxt = 1'b1; out_nxt.last = 1'b1; out_nxt.kind = KIND_RESP;
                out_nxt.number = q_head.item.seq + 32'd1;
                out_nxt.out_seq = cnt_r; cnt_nxt = cnt_r + 32'd1;
                exp_nxt = q_head.item.seq + 32'd1;
                valid_nxt = '0; bact_nxt = 1'b0; ph_nxt = PH_DATA;
              end
            end
            PH_DATA: begin
              if (q_head.cls.is_timeout) begin
                strobe_nxt = 1'b1; out_nxt.last = 1'b1; out_nxt.kind = KIND_DONE;
                ph_nxt = PH_DONE;
              end else begin
                if (q_head.item.seq > hs_r) hs_nxt = q_head.item.seq;
                if (q_head.cls.is_data && q_head.item.seq == exp_r) begin
                  strobe_nxt = 1'b1; out_nxt.kind = KIND_DELIVER;
                  out_nxt.number = q_head.item.seq;
                  out_nxt.data_word = q_head.item.payload;
                  if (!bact_r) begin
                    exp_nxt = exp_r + 32'd1; pend_nxt = exp_r + 32'd1;
                    st_nxt = ST_RESP;
                  end else begin
                    idx_nxt = CW'(1); st_nxt = ST_DR_RD;
                  end
                end else if (q_head.item.seq > exp_r) begin
                  d_nxt = q_head.item.seq - exp_r; rem_nxt = '0; bit_nxt = '0;
                  st_nxt = ST_MOD;
                end else if (q_head.cls.is_data) begin
                  if (!quiet_r) begin
                    strobe_nxt = 1'b1; out_nxt.last = 1'b1; out_nxt.kind = KIND_RESP;
                    out_nxt.number = exp_r; out_nxt.out_seq = cnt_r;
                    cnt_nxt = cnt_r + 32'd1;
                  end
                end else if (q_head.cls.is_eof) begin
                  if (!quiet_r) begin
                    strobe_nxt = 1'b1; out_nxt.last = 1'b1; out_nxt.kind = KIND_RESP;
                    out_nxt.number = q_head.item.seq + 32'd1; out_nxt.out_seq = cnt_r;
                    cnt_nxt = cnt_r + 32'd1;
                  end
                  ph_nxt = PH_EOFCONF;
                end else begin
                  strobe_nxt = 1'b1; out_nxt.last = 1'b1; out_nxt.kind = KIND_DONE;
                  ph_nxt = PH_DONE;
                end
              end
            end
            PH_EOFCONF: begin
              strobe_nxt = 1'b1; out_nxt.last = 1'b1; out_nxt.kind = KIND_DONE;
              ph_nxt = PH_DONE;
            end
            default: ;
          endcase
        end
      end
      ST_RESP: begin
        strobe_nxt = 1'b1; out_nxt.last = 1'b1; out_nxt.kind = KIND_RESP;
        out_nxt.number = pend_r; out_nxt.out_seq = cnt_r; cnt_nxt = cnt_r + 32'd1;
        st_nxt = ST_IDLE;
      end
      ST_MOD: begin
        // restoring remainder, one dividend bit per cycle
        if (rem_sh >= {1'b0, ws_r}) rem_nxt = CW'(rem_sh - {1'b0, ws_r});
        else rem_nxt = rem_sh[CW-1:0];
        d_nxt = {d_r[30:0], 1'b0};
        bit_nxt = bit_r + 5'd1;
        if (bit_r == 5'd31) st_nxt = ST_BUF;
      end
      ST_BUF: begin
        we = 1'b1; waddr = rem_r[IW-1:0];
        wdata = {item_r.cls.is_eof, item_r.item.seq, item_r.item.payload};
        valid_nxt[rem_r[IW-1:0]] = 1'b1;
        bact_nxt = 1'b1; quiet_nxt = 1'b1;
        if (!quiet_r) begin
          strobe_nxt = 1'b1; out_nxt.last = 1'b1; out_nxt.kind = KIND_RESP;
          out_nxt.resp_is_srej = 1'b1; out_nxt.number = exp_r;
          out_nxt.out_seq = cnt_r; cnt_nxt = cnt_r + 32'd1;
        end
        st_nxt = ST_IDLE;
      end
      ST_DR_RD: begin
        raddr = idx_r[IW-1:0];
        if (idx_r < ws_r && valid_r[idx_r[IW-1:0]]) st_nxt = ST_DR_CHK;
        else st_nxt = ST_DR_END;
      end
      ST_DR_CHK: begin
        strobe_nxt = 1'b1;
        if (r_eof) begin
          out_nxt.last = 1'b1; out_nxt.kind = KIND_RESP; out_nxt.number = r_seq + 32'd1;
          out_nxt.out_seq = cnt_r; cnt_nxt = cnt_r + 32'd1;
          ph_nxt = PH_EOFCONF; st_nxt = ST_IDLE;
        end else begin
          out_nxt.kind = KIND_DELIVER; out_nxt.number = r_seq; out_nxt.data_word = r_pay;
          idx_nxt = idx_r + CW'(1); st_nxt = ST_DR_RD;
        end
      end
      ST_DR_END: begin
        exp_nxt = exp_i;
        strobe_nxt = 1'b1; out_nxt.last = 1'b1; out_nxt.kind = KIND_RESP;
        out_nxt.number = exp_i; out_nxt.out_seq = cnt_r; cnt_nxt = cnt_r + 32'd1;
        if (exp_i < hs_r) begin
          out_nxt.resp_is_srej = 1'b1;
          n_nxt = idx_r; idx_nxt = '0; st_nxt = ST_SL_RD;
        end else begin
          valid_nxt = '0; bact_nxt = 1'b0; quiet_nxt = 1'b0; st_nxt = ST_IDLE;
        end
      end
      ST_SL_RD: begin
        raddr = src[IW-1:0];
        if (idx_r >= ws_r) begin
          st_nxt = ST_IDLE;
        end else if (src < {1'b0, ws_r}) begin
          st_nxt = ST_SL_WR;
        end else begin
          valid_nxt[idx_r[IW-1:0]] = 1'b0; idx_nxt = idx_r + CW'(1);
        end
      end
      ST_SL_WR: begin
        we = 1'b1; waddr = idx_r[IW-1:0]; wdata = rdata;
        valid_nxt[idx_r[IW-1:0]] = valid_r[src[IW-1:0]];
        idx_nxt = idx_r + CW'(1); st_nxt = ST_SL_RD;
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE; ph_r <= PH_FILENAME; ws_r <= WMAX_C;
      exp_r <= '0; hs_r <= '0; cnt_r <= '0; quiet_r <= 1'b0; bact_r <= 1'b0;
      valid_r <= '0; out_strobe <= 1'b0;
    end else begin
      st_r <= st_nxt; ph_r <= ph_nxt; ws_r <= ws_nxt;
      exp_r <= exp_nxt; hs_r <= hs_nxt; cnt_r <= cnt_nxt; quiet_r <= quiet_nxt;
      bact_r <= bact_nxt; valid_r <= valid_nxt; out_strobe <= strobe_nxt;
    end
    item_r <= item_nxt; idx_r <= idx_nxt; n_r <= n_nxt; rem_r <= rem_nxt;
    d_r <= d_nxt; bit_r <= bit_nxt; pend_r <= pend_nxt; out_item <= out_nxt;
  end

endmodule
